### rtl/sdac_pkg.sv
// ----------------------------------------------------------------------------
// sdac_pkg
// Types, codes and constants shared by the serial DAC calibrate/write core.
// ----------------------------------------------------------------------------
package sdac_pkg;

	localparam int CODE_BITS_DEF = 20;
	localparam int DATA_BITS     = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	// register indexes on the configuration port
	localparam logic [1:0] REG_SETTLE  = 2'd0;
	localparam logic [1:0] REG_POLL    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] SETTLE_RST  = 16'd600;
	localparam logic [15:0] POLL_RST    = 16'd50;
	localparam logic [15:0] TIMEOUT_RST = 16'd3000;

	// init result codes
	localparam logic [1:0] INIT_NONE    = 2'd0;
	localparam logic [1:0] INIT_BUSY    = 2'd1;
	localparam logic [1:0] INIT_OK      = 2'd2;
	localparam logic [1:0] INIT_TIMEOUT = 2'd3;

	// device command bytes
	localparam logic [7:0] CMD_ADDR_A   = 8'h04;
	localparam logic [7:0] CMD_CFG_A    = 8'h60;
	localparam logic [7:0] CMD_ADDR_B   = 8'h05;
	localparam logic [7:0] CMD_CAL_ON   = 8'h81;
	localparam logic [7:0] CMD_CAL_OFF  = 8'h80;
	localparam logic [7:0] CMD_READ_ST  = 8'h85;
	localparam logic [7:0] CMD_DATA_HI  = 8'h00;
	localparam logic [7:0] CMD_DATA_MID = 8'h01;
	localparam logic [7:0] CMD_DATA_LO  = 8'h02;
	localparam logic [7:0] STATUS_NONE  = 8'hFF;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_START,
		KIND_CODE,
		KIND_STATUS
	} kind_t;

	typedef enum logic [1:0] {
		OP_RESET,
		OP_WRITE,
		OP_READ,
		OP_REPORT
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_AWAIT,
		PH_POLLWAIT
	} phase_t;

	typedef enum logic [2:0] {
		JOB_START,
		JOB_POLL,
		JOB_FINISH,
		JOB_REJECT,
		JOB_CODE
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [1:0]             init_state;
		logic [7:0]             last_status;
		logic [15:0]            status_reads;
		logic [DATA_BITS-1:0]   data;
	} job_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  byte_value;
		logic        last;
		logic [1:0]  init_state;
		logic [7:0]  last_status;
		logic [15:0] status_reads;
		logic        rejected;
	} res_t;

endpackage

### rtl/serial_dac_calibrate_and_write_core.sv
// ----------------------------------------------------------------------------
// serial_dac_calibrate_and_write_core
// Byte-level calibration and code-write controller for a serial DAC.
// ----------------------------------------------------------------------------
// Input: one item per cycle while the four-entry job queue has room.
// An item's job goes through the job queue and then the registered output stage.
// Throughput: one result per cycle from the expander unless the output stalls;
//   code write gives six results, start and finish five, poll two, reject one.
// Reset: sequencer idle, counters cleared, registers at their defaults,
//   queue and output stage empty.
module serial_dac_calibrate_and_write_core #(
	parameter int CODE_BITS = sdac_pkg::CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // code[23:0], status_byte[31:24]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // byte_value[7:0], init_state[9:8],
	                                   // last_status[17:10], status_reads[33:18],
	                                   // rejected[34], zero[39:35]
	output logic [1:0]  m_axis_tuser,  // op[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sdac_pkg::*;

	cfg_wr_t cfg;
	logic    q_full, job_valid, head_valid, pop;
	job_t    job, head;
	res_t    res;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sdac_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_code  (s_axis_tdata[23:0]),
		.in_status(s_axis_tdata[31:24]),
		.cfg      (cfg),
		.q_full   (q_full),
		.job_valid(job_valid),
		.job      (job)
	);

	sdac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_job  (job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	sdac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {5'd0, res.rejected, res.status_reads, res.last_status,
		res.init_state, res.byte_value};
	assign m_axis_tuser = res.op;
	assign m_axis_tlast = res.last;

	// a read request always closes its transaction group
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == OP_READ) |-> m_axis_tlast)
		else $error("read request not marked last");

	// reject flag only on a single closing status report
	a_reject_report: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[34]) |-> (m_axis_tuser == OP_REPORT && m_axis_tlast))
		else $error("reject flag outside a status report");

	// reset pattern is only sent for a calibration in progress
	a_reset_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == OP_RESET) |->
		(m_axis_tdata[9:8] == INIT_BUSY && !m_axis_tlast))
		else $error("reset pattern with wrong init state");

endmodule

### rtl/sdac_front.sv
// ----------------------------------------------------------------------------
// sdac_front
// Accepts input items, runs the calibration sequencer and emits one job per
// item that causes results.
// ----------------------------------------------------------------------------
module sdac_front #(
	parameter int CODE_BITS = sdac_pkg::CODE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     in_kind,
	input  logic [sdac_pkg::DATA_BITS-1:0] in_code,
	input  logic [7:0]                     in_status,
	input  sdac_pkg::cfg_wr_t              cfg,
	input  logic                           q_full,
	output logic                           job_valid,
	output sdac_pkg::job_t                 job
);
	import sdac_pkg::*;

	localparam int MAXV = (1 << CODE_BITS) - 1;

	phase_t      phase_q, phase_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [1:0]  init_q, init_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] polls_q, polls_d;
	logic [15:0] settle_q, poll_q, timeout_q;

	kind_t                kind;
	logic                 accept;
	logic                 tick_due, status_ok, timed_out, waiting;
	logic [15:0]          elapsed_inc, polls_inc;
	logic [DATA_BITS-1:0] code_sat, code_flip, code_dev;
	logic                 jobv;
	job_kind_t            job_kind;

	assign kind        = kind_t'(in_kind);
	assign in_ready    = !q_full;
	assign accept      = in_valid && in_ready;
	assign tick_due    = (wait_q <= 16'd1);
	assign status_ok   = (in_status[1:0] == 2'b00);
	assign timed_out   = (elapsed_q >= timeout_q);
	assign waiting     = (phase_q == PH_SETTLE) || (phase_q == PH_POLLWAIT);
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign polls_inc   = (polls_q == 16'hFFFF) ? polls_q : polls_q + 16'd1;

	// saturate, offset-binary flip, left align in the 24-bit data word
	assign code_sat  = (in_code > DATA_BITS'(MAXV)) ? DATA_BITS'(MAXV) : in_code;
	assign code_flip = code_sat ^ (DATA_BITS'(1) << (CODE_BITS - 1));
	assign code_dev  = code_flip << (DATA_BITS - CODE_BITS);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (kind)
				KIND_TICK: begin
					if (waiting && tick_due) phase_d = PH_AWAIT;
				end
				KIND_START: phase_d = PH_SETTLE;
				KIND_CODE: phase_d = phase_q;
				KIND_STATUS: begin
					if (phase_q == PH_AWAIT)
						phase_d = (status_ok || timed_out) ? PH_IDLE : PH_POLLWAIT;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// counters, results and job
	always_comb begin
		wait_d    = wait_q;
		elapsed_d = elapsed_q;
		init_d    = init_q;
		seen_d    = seen_q;
		polls_d   = polls_q;
		jobv      = 1'b0;
		job_kind  = JOB_POLL;
		if (accept) begin
			unique case (kind)
				KIND_TICK: begin
					if (phase_q == PH_AWAIT || phase_q == PH_POLLWAIT) elapsed_d = elapsed_inc;
					if (waiting) begin
						if (tick_due) begin
							if (phase_q == PH_SETTLE) elapsed_d = 16'd0;
							wait_d   = 16'd0;
							jobv     = 1'b1;
							job_kind = JOB_POLL;
						end else begin
							wait_d = wait_q - 16'd1;
						end
					end
				end
				KIND_START: begin
					init_d    = INIT_BUSY;
					seen_d    = STATUS_NONE;
					polls_d   = 16'd0;
					elapsed_d = 16'd0;
					wait_d    = settle_q;
					jobv      = 1'b1;
					job_kind  = JOB_START;
				end
				KIND_CODE: begin
					jobv     = 1'b1;
					job_kind = (phase_q != PH_IDLE) ? JOB_REJECT : JOB_CODE;
				end
				KIND_STATUS: begin
					if (phase_q == PH_AWAIT) begin
						seen_d  = in_status;
						polls_d = polls_inc;
						if (status_ok || timed_out) begin
							init_d   = status_ok ? INIT_OK : INIT_TIMEOUT;
							wait_d   = 16'd0;
							jobv     = 1'b1;
							job_kind = JOB_FINISH;
						end else begin
							wait_d = (poll_q == 16'd0) ? 16'd1 : poll_q;
						end
					end
				end
				default: jobv = 1'b0;
			endcase
		end
	end

	assign job_valid        = jobv;
	assign job.kind         = job_kind;
	assign job.init_state   = init_d;
	assign job.last_status  = seen_d;
	assign job.status_reads = polls_d;
	assign job.data         = code_dev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wait_q    <= 16'd0;
			elapsed_q <= 16'd0;
			init_q    <= INIT_NONE;
			seen_q    <= STATUS_NONE;
			polls_q   <= 16'd0;
		end else begin
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			elapsed_q <= elapsed_d;
			init_q    <= init_d;
			seen_q    <= seen_d;
			polls_q   <= polls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q  <= SETTLE_RST;
			poll_q    <= POLL_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SETTLE:  settle_q  <= cfg.data;
				REG_POLL:    poll_q    <= cfg.data;
				REG_TIMEOUT: timeout_q <= cfg.data;
				default:     settle_q  <= settle_q;
			endcase
		end
	end

endmodule

### rtl/sdac_queue.sv
// ----------------------------------------------------------------------------
// sdac_queue
// Small job queue between the sequencer and the bus-operation expander.
// ----------------------------------------------------------------------------
module sdac_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sdac_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output sdac_pkg::job_t head
);
	import sdac_pkg::*;

	job_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push, do_pop;

	assign full       = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/sdac_back.sv
// ----------------------------------------------------------------------------
// sdac_back
// Expands each queued job into its bus operations, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sdac_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  sdac_pkg::job_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output sdac_pkg::res_t res
);
	import sdac_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	res_t       res_q;
	op_t        op_c;
	logic [7:0] byte_c;
	logic       rej_c, final_c, advance;

	always_comb begin
		op_c    = OP_WRITE;
		byte_c  = 8'h00;
		rej_c   = 1'b0;
		final_c = 1'b0;
		unique case (head.kind)
			JOB_START: begin
				case (step_q)
					3'd0:    op_c   = OP_RESET;
					3'd1:    byte_c = CMD_ADDR_A;
					3'd2:    byte_c = CMD_CFG_A;
					3'd3:    byte_c = CMD_ADDR_B;
					default: begin
						byte_c  = CMD_CAL_ON;
						final_c = 1'b1;
					end
				endcase
			end
			JOB_POLL: begin
				if (step_q == 3'd0) begin
					byte_c = CMD_READ_ST;
				end else begin
					op_c    = OP_READ;
					final_c = 1'b1;
				end
			end
			JOB_FINISH: begin
				case (step_q)
					3'd0:    byte_c = CMD_ADDR_A;
					3'd1:    byte_c = CMD_CFG_A;
					3'd2:    byte_c = CMD_ADDR_B;
					3'd3:    byte_c = CMD_CAL_OFF;
					default: begin
						op_c    = OP_REPORT;
						final_c = 1'b1;
					end
				endcase
			end
			JOB_REJECT: begin
				op_c    = OP_REPORT;
				rej_c   = 1'b1;
				final_c = 1'b1;
			end
			JOB_CODE: begin
				case (step_q)
					3'd0:    byte_c = CMD_DATA_HI;
					3'd1:    byte_c = head.data[23:16];
					3'd2:    byte_c = CMD_DATA_MID;
					3'd3:    byte_c = head.data[15:8];
					3'd4:    byte_c = CMD_DATA_LO;
					default: begin
						byte_c  = head.data[7:0];
						final_c = 1'b1;
					end
				endcase
			end
			default: final_c = 1'b1;
		endcase
	end

	assign advance   = head_valid && (!out_valid_q || out_ready);
	assign pop       = advance && final_c;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 3'd0;
		end else begin
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (advance) step_q <= final_c ? 3'd0 : step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.op           <= op_c;
			res_q.byte_value   <= byte_c;
			res_q.last         <= final_c;
			res_q.init_state   <= head.init_state;
			res_q.last_status  <= head.last_status;
			res_q.status_reads <= head.status_reads;
			res_q.rejected     <= rej_c;
		end
	end

endmodule
